@@ rtl/isrt_pkg.sv @@
// isrt_pkg: shared types and fixed constants of the insertion sorter
// no dependencies; imported by every module of the block

package isrt_pkg;

  // fixed widths of the port fields
  localparam int unsigned IN_W      = 16;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned SHIFT_W   = 9;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = '1;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // classification that travels with each queued request
  typedef struct packed {
    logic last;  // request closes the data set
    logic drop;  // store was full, value is not kept
  } item_tag_t;

  localparam int unsigned TAG_W = $bits(item_tag_t);

endpackage

@@ rtl/isrt_queue.sv @@
// isrt_queue: small fifo that decouples request classification from sorting
// depends on isrt_pkg for depth and pointer width

module isrt_queue
  import isrt_pkg::*;
#(
  parameter int unsigned DATA_W = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);

  logic [DATA_W-1:0] slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   fill_q, fill_d;

  // status flags
  assign full_o  = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // storage slots, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/isrt_front.sv @@
// isrt_front: accepts requests, wraps the value and tags store overflow and set end
// depends on isrt_pkg; feeds isrt_queue

module isrt_front
  import isrt_pkg::*;
#(
  parameter int unsigned MAX_ITEMS   = 32,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [IN_W-1:0]        value_i,
  input  logic                          last_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output logic signed [VALUE_WIDTH-1:0] q_value_o,
  output item_tag_t                     q_tag_o
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0] seen_q, seen_d;
  logic          accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept;

  // wrap to the storage width (sign-extends or truncates)
  assign q_value_o = VALUE_WIDTH'(value_i);

  // classify against the number of values already kept in this set
  assign q_tag_o.last = last_i;
  assign q_tag_o.drop = (seen_q == CW'(MAX_ITEMS));

  always_comb begin
    seen_d = seen_q;
    if (accept) begin
      if (last_i) begin
        seen_d = '0;
      end else if (!q_tag_o.drop) begin
        seen_d = seen_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

endmodule

@@ rtl/isrt_back.sv @@
// isrt_back: inserts each queued value into the sorted store and emits the set
// depends on isrt_pkg; memory for the store lives here

module isrt_back
  import isrt_pkg::*;
#(
  parameter int unsigned MAX_ITEMS   = 32,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  logic signed [VALUE_WIDTH-1:0] q_value_i,
  input  item_tag_t                     q_tag_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [OUT_W-1:0]       sorted_value_o,
  output logic                          last_res_o,
  output logic [SHIFT_W-1:0]            shift_count_o,
  output logic                          dropped_o
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_LOOK      = 6'b000010,
    ST_CMP       = 6'b000100,
    ST_EMIT_RD   = 6'b001000,
    ST_EMIT_LD   = 6'b010000,
    ST_EMIT_WAIT = 6'b100000
  } back_state_e;

  back_state_e state_q, state_d;

  logic signed [VALUE_WIDTH-1:0] store_mem [MAX_ITEMS];
  logic signed [VALUE_WIDTH-1:0] rd_data_q;
  logic                          mem_we;
  logic [IW-1:0]                 mem_waddr, mem_raddr;
  logic signed [VALUE_WIDTH-1:0] mem_wdata;

  logic signed [VALUE_WIDTH-1:0] key_q, key_d;
  logic [CW-1:0]                 pos_q, pos_d, pos_m1, pos_m2;
  logic [CW-1:0]                 cnt_q, cnt_d, cnt_p1;
  logic [CW-1:0]                 idx_q, idx_d, idx_p1;
  logic [SHIFT_W-1:0]            shift_q, shift_d;
  logic                          ovf_q, ovf_d;
  logic                          set_end_q, set_end_d;

  logic                          out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0]       out_value_q, out_value_d;
  logic                          out_last_q, out_last_d;
  logic [SHIFT_W-1:0]            out_shift_q, out_shift_d;
  logic                          out_drop_q, out_drop_d;

  assign pos_m1 = pos_q - CW'(1);
  assign pos_m2 = pos_q - CW'(2);
  assign cnt_p1 = cnt_q + CW'(1);
  assign idx_p1 = idx_q + CW'(1);

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_res_o     = out_last_q;
  assign shift_count_o  = out_shift_q;
  assign dropped_o      = out_drop_q;

  // insertion walk and emit sequencer
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    shift_d     = shift_q;
    ovf_d       = ovf_q;
    set_end_d   = set_end_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_shift_d = out_shift_q;
    out_drop_d  = out_drop_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pos_q[IW-1:0];
    mem_wdata   = key_q;
    mem_raddr   = pos_m1[IW-1:0];

    case (state_q)
      // take the next request from the queue
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_tag_i.drop) begin
            ovf_d = 1'b1;
            if (q_tag_i.last) begin
              idx_d   = '0;
              state_d = ST_EMIT_RD;
            end
          end else begin
            key_d     = q_value_i;
            pos_d     = cnt_q;
            set_end_d = q_tag_i.last;
            state_d   = ST_LOOK;
          end
        end
      end

      // slot zero reached or start reading the left neighbor
      ST_LOOK: begin
        if (pos_q == '0) begin
          mem_we = 1'b1;
          cnt_d  = cnt_p1;
          if (set_end_q) begin
            idx_d   = '0;
            state_d = ST_EMIT_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          mem_raddr = pos_m1[IW-1:0];
          state_d   = ST_CMP;
        end
      end

      // neighbor larger: move it up and read the next one, else drop the key in
      ST_CMP: begin
        mem_we = 1'b1;
        if (rd_data_q > key_q) begin
          mem_wdata = rd_data_q;
          pos_d     = pos_m1;
          if (shift_q != SHIFT_MAX) begin
            shift_d = shift_q + 1'b1;
          end
          if (pos_q == CW'(1)) begin
            state_d = ST_LOOK;
          end else begin
            mem_raddr = pos_m2[IW-1:0];
          end
        end else begin
          cnt_d = cnt_p1;
          if (set_end_q) begin
            idx_d   = '0;
            state_d = ST_EMIT_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      // read the next sorted entry
      ST_EMIT_RD: begin
        mem_raddr = idx_q[IW-1:0];
        state_d   = ST_EMIT_LD;
      end

      // load the output register
      ST_EMIT_LD: begin
        out_valid_d = 1'b1;
        out_value_d = OUT_W'(rd_data_q);
        out_last_d  = (idx_p1 == cnt_q);
        out_shift_d = (idx_p1 == cnt_q) ? shift_q : '0;
        out_drop_d  = (idx_p1 == cnt_q) && ovf_q;
        state_d     = ST_EMIT_WAIT;
      end

      // wait for the result to be taken
      ST_EMIT_WAIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            cnt_d   = '0;
            shift_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_p1;
            state_d = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      shift_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      set_end_q   <= 1'b0;
      pos_q       <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      shift_q     <= shift_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      set_end_q   <= set_end_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_shift_q <= out_shift_d;
    out_drop_q  <= out_drop_d;
  end

  // value store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= store_mem[mem_raddr];
  end

endmodule

@@ rtl/insertion_sorter.sv @@
// insertion_sorter: top level, front classifier, request queue and sorting back end
// depends on isrt_pkg, isrt_front, isrt_queue, isrt_back
//
//   channel | direction | handshake                 | payload
//   input   | in        | in_valid_i / in_ready_o   | value_i, last_i
//   output  | out       | out_valid_o / out_ready_i | sorted_value_o, last_res_o,
//           |           |                           | shift_count_o, dropped_o
//
// each request is inserted into the sorted store as it arrives: each larger stored value
// moves up one slot in turn until a value no larger or slot zero is found, then the value
// is written in; the walk uses the one write port and one registered read port of the store
// a 4-entry queue takes requests while the back end is busy; in_ready_o drops when it fills
// on a request marked last, the results follow in ascending order, each held until taken
// reset is asynchronous and clears all control state; the store needs no clearing

module insertion_sorter
  import isrt_pkg::*;
#(
  parameter int unsigned MAX_ITEMS   = 32,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [IN_W-1:0]  value_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] sorted_value_o,
  output logic                    last_res_o,
  output logic [SHIFT_W-1:0]      shift_count_o,
  output logic                    dropped_o
);

  localparam int unsigned QW = VALUE_WIDTH + TAG_W;

  logic                          q_push, q_pop, q_full, q_empty;
  logic signed [VALUE_WIDTH-1:0] push_value, pop_value;
  item_tag_t                     push_tag, pop_tag;
  logic [QW-1:0]                 pop_data;

  // request classification
  isrt_front #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .value_i   (value_i),
    .last_i    (last_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_value_o (push_value),
    .q_tag_o   (push_tag)
  );

  // queue between front and back
  isrt_queue #(
    .DATA_W(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i ({push_tag, push_value}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (pop_data),
    .empty_o(q_empty)
  );

  assign pop_tag   = pop_data[QW-1 -: TAG_W];
  assign pop_value = pop_data[VALUE_WIDTH-1:0];

  // insertion and output
  isrt_back #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_value_i     (pop_value),
    .q_tag_i       (pop_tag),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .last_res_o    (last_res_o),
    .shift_count_o (shift_count_o),
    .dropped_o     (dropped_o)
  );

`ifndef NO_ASSERTIONS
  // no new request is drawn from the queue while a result is on offer
  a_no_pop_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !q_pop)
    else $error("queue popped while a result is pending");

  // shift total appears only on the final result of a set
  a_shift_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_res_o) |-> (shift_count_o == '0))
    else $error("shift count on a non-final result");

  // overflow flag appears only on the final result of a set
  a_drop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_o) |-> last_res_o)
    else $error("dropped flag on a non-final result");
`endif

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench of the insertion sorter, driver and monitor as clocked blocks
// depends on isrt_pkg and insertion_sorter; predicts each sorted set and checks every result

module tb_top;
  import isrt_pkg::*;

  localparam int unsigned MAX_ITEMS    = 32;
  localparam int unsigned VALUE_WIDTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 320;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef enum int {
    SET_RANDOM,
    SET_DESCENDING,
    SET_ASCENDING,
    SET_NARROW,
    SET_EQUAL
  } set_kind_e;

  typedef struct {
    logic signed [IN_W-1:0] value;
    logic                   last;
  } in_req_t;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    last;
    logic [SHIFT_W-1:0]      shifts;
    logic                    dropped;
  } sorted_res_t;

  // block ports
  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic signed [IN_W-1:0]  value_i        = '0;
  logic                    last_i         = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b0;
  logic signed [OUT_W-1:0] sorted_value_o;
  logic                    last_res_o;
  logic [SHIFT_W-1:0]      shift_count_o;
  logic                    dropped_o;

  // testbench state
  in_req_t                 pending_q[$];
  sorted_res_t             exp_sorted_q[$];
  logic signed [OUT_W-1:0] set_store[$];
  logic                    set_overflow = 1'b0;
  int unsigned             err_count    = 0;
  int unsigned             cycle_cnt    = 0;
  int unsigned             rand_items   = 0;
  int                      burst_left   = 1;
  int                      gap_left     = 0;
  int                      stall_left   = 0;
  int                      stall_mode   = 0;
  int                      mode_left    = 0;
  logic                    rdy_next;
  in_req_t                 drv_req;
  sorted_res_t             mon_want;

  insertion_sorter #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sorted_value_o(sorted_value_o),
    .last_res_o    (last_res_o),
    .shift_count_o (shift_count_o),
    .dropped_o     (dropped_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
    err_count++;
  endtask

  // collect one accepted request; on last, sort the set and queue its results
  task automatic sort_request(input logic signed [IN_W-1:0] v, input logic is_last);
    logic signed [OUT_W-1:0] key;
    sorted_res_t             res;
    int                      i;
    int                      j;
    int unsigned             shifts;
    if (set_store.size() < MAX_ITEMS) begin
      // width is 16 here, so the wrap to the value width keeps the value
      set_store.insert(set_store.size(), v);
    end else begin
      set_overflow = 1'b1;
    end
    if (!is_last) return;
    shifts = 0;
    for (i = 1; i < set_store.size(); i++) begin
      key = set_store[i];
      j   = i - 1;
      while (j >= 0 && set_store[j] > key) begin
        set_store[j+1] = set_store[j];
        if (shifts < SHIFT_MAX) shifts++;
        j--;
      end
      set_store[j+1] = key;
    end
    for (i = 0; i < set_store.size(); i++) begin
      res.value   = set_store[i];
      res.last    = (i == set_store.size() - 1);
      res.shifts  = res.last ? shifts[SHIFT_W-1:0] : '0;
      res.dropped = res.last && set_overflow;
      exp_sorted_q.insert(exp_sorted_q.size(), res);
    end
    set_store.delete();
    set_overflow = 1'b0;
  endtask

  task automatic add_req(input logic signed [IN_W-1:0] v, input logic is_last);
    in_req_t r;
    r.value = v;
    r.last  = is_last;
    pending_q.insert(pending_q.size(), r);
  endtask

  // one data set of n values of the given shape, last marked on the final one
  task automatic add_set(input set_kind_e kind, input int n);
    int k;
    int v;
    int eq_val;
    eq_val = $urandom_range(0, 65535) - 32768;
    if (kind == SET_DESCENDING) v = 32767 - $urandom_range(0, 255);
    else v = -32768 + $urandom_range(0, 255);
    for (k = 0; k < n; k++) begin
      case (kind)
        SET_DESCENDING: begin
          if (k > 0) v = v - $urandom_range(1, 700);
        end
        SET_ASCENDING: begin
          if (k > 0) v = v + $urandom_range(0, 700);
        end
        SET_NARROW: begin
          v = $urandom_range(0, 7) - 4;
        end
        SET_EQUAL: begin
          v = eq_val;
        end
        default: begin
          v = $urandom_range(0, 65535) - 32768;
        end
      endcase
      add_req(v[IN_W-1:0], k == n - 1);
    end
    rand_items += n;
  endtask

  // driver: bursts of requests with random gaps, predictor fed on each accept
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
      last_i     <= 1'b0;
    end else begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) sort_request(value_i, last_i);
        if (gap_left > 0 || pending_q.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          drv_req = pending_q.pop_front();
          in_valid_i <= 1'b1;
          value_i    <= drv_req.value;
          last_i     <= drv_req.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // monitor: check each accepted result, then pick the next ready level
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (exp_sorted_q.size() == 0) begin
          report_error($sformatf("unexpected result value %0d", sorted_value_o));
        end else begin
          mon_want = exp_sorted_q.pop_front();
          if (sorted_value_o !== mon_want.value)
            report_error($sformatf("sorted_value got %0d want %0d",
                                   sorted_value_o, mon_want.value));
          if (last_res_o !== mon_want.last)
            report_error($sformatf("last_res got %0b want %0b", last_res_o, mon_want.last));
          if (shift_count_o !== mon_want.shifts)
            report_error($sformatf("shift_count got %0d want %0d",
                                   shift_count_o, mon_want.shifts));
          if (dropped_o !== mon_want.dropped)
            report_error($sformatf("dropped got %0b want %0b", dropped_o, mon_want.dropped));
        end
      end
      // stall pattern: always ready, sparse stalls, long stalls, or alternating ready and stall
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy_next = 1'b0;
      end else begin
        case (stall_mode)
          1: rdy_next = ($urandom_range(0, 3) != 0);
          2: begin
            rdy_next = 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
          end
          3: rdy_next = !out_ready_i;
          default: rdy_next = 1'b1;
        endcase
      end
      out_ready_i <= rdy_next;
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int        r;
    int        n;
    set_kind_e kind;

    // single value at the negative extreme
    add_req(-16'sd32768, 1'b1);
    // two extremes in reverse order
    add_req(16'sd32767, 1'b0);
    add_req(-16'sd32768, 1'b1);
    // duplicates
    add_req(16'sd0, 1'b0);
    add_req(-16'sd1, 1'b0);
    add_req(16'sd0, 1'b0);
    add_req(-16'sd1, 1'b1);
    // already sorted, no shifts
    add_req(16'sd1, 1'b0);
    add_req(16'sd2, 1'b0);
    add_req(16'sd3, 1'b0);
    add_req(16'sd4, 1'b1);
    // alternating bit patterns and extremes
    add_req(16'h5555, 1'b0);
    add_req(16'hAAAA, 1'b0);
    add_req(16'sd32767, 1'b0);
    add_req(-16'sd32768, 1'b0);
    add_req(16'sd0, 1'b0);
    add_req(-16'sd1, 1'b0);
    add_req(16'sd1, 1'b1);

    // full store in reverse order gives the most shifts
    add_set(SET_DESCENDING, MAX_ITEMS);
    // one past capacity: the last value itself is dropped
    add_set(SET_RANDOM, MAX_ITEMS + 1);
    while (rand_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      case (r)
        0: begin kind = SET_DESCENDING; n = MAX_ITEMS; end
        1: begin kind = SET_RANDOM;     n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8); end
        2: begin kind = SET_ASCENDING;  n = $urandom_range(1, 12); end
        3: begin kind = SET_NARROW;     n = $urandom_range(2, 16); end
        4: begin kind = SET_EQUAL;      n = $urandom_range(2, 6); end
        5: begin kind = SET_RANDOM;     n = MAX_ITEMS; end
        default: begin kind = SET_RANDOM; n = $urandom_range(1, 10); end
      endcase
      add_set(kind, n);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid_i || exp_sorted_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
